// File: rtl/core/rrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared sizes, codes and types of the recurrence row threshold unit.
// ----------------------------------------------------------------------------
package rrt_pkg;

    // Store geometry
    localparam int MAX_POINTS  = 64;
    localparam int MAX_DIMS    = 8;
    localparam int PT_W        = $clog2(MAX_POINTS);
    localparam int DIM_W       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int STORE_DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int PDIM_W      = $clog2(MAX_DIMS + 1);

    // Field and register widths
    localparam int SAMPLE_W    = 16;
    localparam int DIST_W      = 35;
    localparam int SQ_W        = 2 * (SAMPLE_W + 1);
    localparam int ACC_W       = DIST_W + 1;
    localparam int IDX_W       = 6;
    localparam int DIDX_W      = 3;
    localparam int NBR_W       = 7;
    localparam int PTS_W       = 7;
    localparam int DIMS_W      = 4;
    localparam int CFG_W       = 35;
    localparam int CFG_IDX_W   = 2;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS      = 2'd3;

    // Sequencer states
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIST  = 9'b000000010,
        S_DRAIN = 9'b000000100,
        S_KLOAD = 9'b000001000,
        S_KCAP  = 9'b000010000,
        S_KSCAN = 9'b000100000,
        S_MASK  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_SPARE = 9'b100000000
    } t_state;

endpackage

// File: rtl/core/rrt_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_req_if / rrt_rsp_if
// Valid/ready channels for input requests and row results.
// ----------------------------------------------------------------------------
interface rrt_req_if;
    import rrt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [IDX_W-1:0]           point_index;
    logic [DIDX_W-1:0]          dim_index;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, command, point_index, dim_index, sample, last,
                    input ready);
    modport sink   (input valid, command, point_index, dim_index, sample, last,
                    output ready);
endinterface

interface rrt_rsp_if;
    import rrt_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  row_index;
    logic [63:0]       row_bits;
    logic [DIST_W-1:0] row_threshold_sq;

    modport source (output valid, row_index, row_bits, row_threshold_sq, input ready);
    modport sink   (input valid, row_index, row_bits, row_threshold_sq, output ready);
endinterface

// File: rtl/core/rrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/recurrence_row_threshold_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recurrence_row_threshold_unit
// Builds one row of a recurrence plot against a store of reference points.
// ----------------------------------------------------------------------------
// Requests arrive on i_req. A load request writes one component of a
// reference point into the reference RAM. A query request writes one
// component of the query vector; with last set it starts a row.
// While a row is being built, i_req.ready is low.
// A row is built in passes: first a distance pass (one reference RAM read
// per cycle through a three-stage read, subtract-and-square, accumulate
// pipe), then in neighbour mode a k-th smallest search that tries the
// points' distances as candidates in turn, each against a full scan, until
// one is the answer, then a mask pass over the distance RAM, then the load
// of the result register.
// The single read port of the distance RAM sets the search and mask cost.
// The result waits in o_rsp until taken; loads are still accepted meanwhile,
// and a following row holds its result internally until the register frees.
// Configuration must be written over i_cfg_* only while the block is idle;
// the block itself does not enforce this. Reset brings the registers to
// their defaults (radius 0, radius mode, 64 points, 1 dimension); the RAMs
// are not cleared and hold no meaning until written.
// ----------------------------------------------------------------------------
module recurrence_row_threshold_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rrt_req_if.sink                        i_req,
    rrt_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [rrt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrt_pkg::CFG_W-1:0]      i_cfg_data
);
    import rrt_pkg::*;

    // Configuration registers
    logic [DIST_W-1:0] r_thr_cfg;
    logic [NBR_W-1:0]  r_nbr;
    logic [PTS_W-1:0]  r_pts;
    logic [DIMS_W-1:0] r_dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_cfg <= '0;
            r_nbr     <= '0;
            r_pts     <= PTS_W'(MAX_POINTS);
            r_dims    <= DIMS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr_cfg <= i_cfg_data[DIST_W-1:0];
                CFG_NEIGHBOUR: r_nbr     <= i_cfg_data[NBR_W-1:0];
                CFG_POINTS:    r_pts     <= i_cfg_data[PTS_W-1:0];
                CFG_DIMS:      r_dims    <= i_cfg_data[DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped row length, dimension count and neighbour count
    logic [CNT_W-1:0]  n_pts;
    logic [PT_W-1:0]   last_pt;
    logic [PDIM_W-1:0] n_dims;
    logic [DIM_W-1:0]  last_dim;
    logic [CNT_W-1:0]  n_k;

    always_comb begin
        if (r_pts == '0) begin
            n_pts = CNT_W'(1);
        end else if (CNT_W'(r_pts) > CNT_W'(MAX_POINTS)) begin
            n_pts = CNT_W'(MAX_POINTS);
        end else begin
            n_pts = CNT_W'(r_pts);
        end
        if (r_dims == '0) begin
            n_dims = PDIM_W'(1);
        end else if (32'(r_dims) > 32'(MAX_DIMS)) begin
            n_dims = PDIM_W'(MAX_DIMS);
        end else begin
            n_dims = PDIM_W'(r_dims);
        end
        last_pt  = PT_W'(n_pts - CNT_W'(1));
        last_dim = DIM_W'(n_dims - PDIM_W'(1));
        n_k      = (CNT_W'(r_nbr) > n_pts) ? n_pts : CNT_W'(r_nbr);
    end

    t_state r_state;

    // Request handshake
    logic req_fire;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    logic dim_ok;
    assign dim_ok = (32'(i_req.dim_index) < 32'(MAX_DIMS));

    // Query vector registers
    logic signed [SAMPLE_W-1:0] r_qvec [MAX_DIMS];

    always_ff @(posedge i_clk) begin
        if (req_fire && i_req.command == CMD_QUERY && dim_ok) begin
            r_qvec[DIM_W'(i_req.dim_index)] <= i_req.sample;
        end
    end

    // Sequencer counters and pipe tags
    logic [PT_W-1:0]   r_j;
    logic [DIM_W-1:0]  r_d;
    logic [PT_W-1:0]   r_i;
    logic              r_issuing;
    logic              r_s1_v, r_s1_first, r_s1_lastd;
    logic [DIM_W-1:0]  r_s1_d;
    logic [PT_W-1:0]   r_s1_j;
    logic              r_s2_v, r_s2_first, r_s2_lastd;
    logic [PT_W-1:0]   r_s2_j;
    logic [SQ_W-2:0]   r_s2_sq;
    logic [ACC_W-1:0]  r_acc;
    logic              r_t_v, r_t_last;
    logic [PT_W-1:0]   r_t_j;
    logic [DIST_W-1:0] r_cand;
    logic [CNT_W-1:0]  r_less, r_le;
    logic [DIST_W-1:0] r_thr;
    logic [63:0]       r_bits;
    logic [IDX_W-1:0]  r_row;

    // Reference RAM
    logic                         ref_we;
    logic [$clog2(STORE_DEPTH)-1:0] ref_waddr, ref_raddr;
    logic [SAMPLE_W-1:0]          ref_rdata;
    logic                         ref_re;

    assign ref_we    = req_fire && (i_req.command == CMD_LOAD) && dim_ok &&
                       (32'(i_req.point_index) < 32'(MAX_POINTS));
    assign ref_waddr = {PT_W'(i_req.point_index), DIM_W'(i_req.dim_index)};
    assign ref_re    = (r_state == S_DIST);
    assign ref_raddr = {r_j, r_d};

    rrt_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (i_req.sample),
        .i_re    (ref_re),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    // Distance pipe: difference and square, then accumulate over dimensions
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SQ_W-1:0]     sq_full;
    logic [ACC_W-1:0]           acc_n;
    logic [DIST_W-1:0]          dist_sat;

    assign diff     = (SAMPLE_W+1)'(r_qvec[r_s1_d]) - (SAMPLE_W+1)'($signed(ref_rdata));
    assign sq_full  = diff * diff;
    assign acc_n    = (r_s2_first ? '0 : r_acc) + ACC_W'(r_s2_sq);
    assign dist_sat = acc_n[ACC_W-1] ? {DIST_W{1'b1}} : acc_n[DIST_W-1:0];

    // Distance RAM
    logic              dist_we, dist_re;
    logic [PT_W-1:0]   dist_raddr;
    logic [DIST_W-1:0] dist_rdata;

    assign dist_we    = r_s2_v && r_s2_lastd;
    assign dist_re    = (r_state == S_KLOAD) || r_issuing;
    assign dist_raddr = (r_state == S_KLOAD) ? r_i : r_j;

    rrt_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (r_s2_j),
        .i_wdata (dist_sat),
        .i_re    (dist_re),
        .i_raddr (dist_raddr),
        .o_rdata (dist_rdata)
    );

    // Counting for the k-th smallest search
    logic [CNT_W-1:0] less_n, le_n;
    logic             found;

    assign less_n = r_less + CNT_W'(r_t_v && (dist_rdata < r_cand));
    assign le_n   = r_le + CNT_W'(r_t_v && (dist_rdata <= r_cand));
    assign found  = (less_n < n_k) && (n_k <= le_n);

    // Result register
    logic              r_out_valid;
    logic [63:0]       r_out_bits;
    logic [DIST_W-1:0] r_out_thr;
    logic [IDX_W-1:0]  r_out_row;
    logic              out_free;

    assign out_free = !r_out_valid || o_rsp.ready;

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issuing   <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_t_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Pipe tags advance every cycle
            r_s1_v     <= (r_state == S_DIST);
            r_s1_d     <= r_d;
            r_s1_j     <= r_j;
            r_s1_first <= (r_d == '0);
            r_s1_lastd <= (r_d == last_dim);
            r_s2_v     <= r_s1_v;
            r_s2_j     <= r_s1_j;
            r_s2_first <= r_s1_first;
            r_s2_lastd <= r_s1_lastd;
            r_s2_sq    <= sq_full[SQ_W-2:0];
            if (r_s2_v) begin
                r_acc <= acc_n;
            end
            r_t_v    <= r_issuing;
            r_t_j    <= r_j;
            r_t_last <= r_issuing && (r_j == last_pt);
            if (r_issuing) begin
                r_j <= r_j + PT_W'(1);
                if (r_j == last_pt) begin
                    r_issuing <= 1'b0;
                end
            end

            // The result holds until taken; a finished row loads it once it frees.
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_j <= '0;
                    r_d <= '0;
                    if (req_fire && i_req.command == CMD_QUERY && i_req.last) begin
                        r_row   <= i_req.point_index;
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    if (r_d == last_dim) begin
                        r_d <= '0;
                        r_j <= r_j + PT_W'(1);
                        if (r_j == last_pt) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_d <= r_d + DIM_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_v && !r_s2_v) begin
                        r_j <= '0;
                        r_i <= '0;
                        if (n_k == '0) begin
                            r_thr     <= r_thr_cfg;
                            r_bits    <= '0;
                            r_issuing <= 1'b1;
                            r_state   <= S_MASK;
                        end else begin
                            r_state <= S_KLOAD;
                        end
                    end
                end
                S_KLOAD: begin
                    r_state <= S_KCAP;
                end
                S_KCAP: begin
                    r_cand    <= dist_rdata;
                    r_less    <= '0;
                    r_le      <= '0;
                    r_j       <= '0;
                    r_issuing <= 1'b1;
                    r_state   <= S_KSCAN;
                end
                S_KSCAN: begin
                    r_less <= less_n;
                    r_le   <= le_n;
                    if (r_t_v && r_t_last) begin
                        if (found || r_i == last_pt) begin
                            r_thr     <= found ? r_cand : '0;
                            r_bits    <= '0;
                            r_j       <= '0;
                            r_issuing <= 1'b1;
                            r_state   <= S_MASK;
                        end else begin
                            r_i     <= r_i + PT_W'(1);
                            r_state <= S_KLOAD;
                        end
                    end
                end
                S_MASK: begin
                    if (r_t_v && (dist_rdata < r_thr)) begin
                        r_bits[r_t_j] <= 1'b1;
                    end
                    if (r_t_v && r_t_last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_bits  <= r_bits;
                        r_out_thr   <= r_thr;
                        r_out_row   <= r_row;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.row_index        = r_out_row;
    assign o_rsp.row_bits         = r_out_bits;
    assign o_rsp.row_threshold_sq = r_out_thr;

    // Distance pipe runs only during the distance pass and its drain
    a_pipe_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_state == S_DIST || r_state == S_DRAIN))
        else $error("distance pipe active outside the distance pass");

    // Distance RAM read tags only during the search and mask passes
    a_tag_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t_v |-> (r_state == S_KSCAN || r_state == S_MASK))
        else $error("distance read tag outside a scan");

    // No mask bit at or above the row length
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ((r_bits >> n_pts) == 64'd0))
        else $error("row mask has bits beyond the row length");

    // A new result appears only from the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output state");
endmodule

// File: verif/recurrence_row_threshold_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recurrence_row_threshold_unit_tb
// Self-checking bench for the recurrence row threshold unit.
// ----------------------------------------------------------------------------
// The bench fills the reference store first, so no row ever reads an unwritten
// entry. Directed rows then cover sample extremes, ties in neighbour mode and
// loads that carry last. After that, random phases run under different
// register settings, the extremes among them. A local row predictor mirrors
// the stores and the registers and queues one expected row per query that
// carries last. Each taken result is checked field by field against the
// oldest expected row. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module recurrence_row_threshold_unit_tb;
    import rrt_pkg::*;

    localparam int  IDLE_LIMIT = 40000;
    localparam int  SETTLE     = 20;
    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    typedef struct {
        logic                cmd;
        logic [IDX_W-1:0]    pt;
        logic [DIDX_W-1:0]   dim;
        logic [SAMPLE_W-1:0] smp;
        logic                last;
    } req_t;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [63:0]       bits;
        logic [DIST_W-1:0] thr;
    } row_t;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    rrt_req_if req_if ();
    rrt_rsp_if rsp_if ();

    recurrence_row_threshold_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Mirror of the block state and registers.
    logic signed [SAMPLE_W-1:0] ref_points [MAX_POINTS][MAX_DIMS];
    logic signed [SAMPLE_W-1:0] query_vec [MAX_DIMS];
    logic [DIST_W-1:0] radius_sq;
    logic [NBR_W-1:0]  nbr_count;
    logic [PTS_W-1:0]  n_points;
    logic [DIMS_W-1:0] n_dims;

    row_t rows_pending [$];
    int   errors;
    bit   jitter_on;
    int   idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Random gap length: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        if (!jitter_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7FFF;
        if (r == 2) return 16'h0000;
        return 16'($urandom);
    endfunction

    // Expected row for a query that carries last.
    function automatic row_t predict_row(input logic [IDX_W-1:0] idx);
        int     n, p, k;
        longint dist_row [MAX_POINTS];
        longint sorted [$];
        longint sum, diff;
        row_t   r;
        n = (n_points < 1) ? 1 : (n_points > MAX_POINTS) ? MAX_POINTS : int'(n_points);
        p = (n_dims < 1) ? 1 : (n_dims > MAX_DIMS) ? MAX_DIMS : int'(n_dims);
        for (int j = 0; j < n; j++) begin
            sum = 0;
            for (int d = 0; d < p; d++) begin
                diff = longint'(query_vec[d]) - longint'(ref_points[j][d]);
                sum += diff * diff;
            end
            dist_row[j] = (sum > longint'(DIST_SAT)) ? longint'(DIST_SAT) : sum;
            sorted.push_back(dist_row[j]);
        end
        k = (nbr_count > n) ? n : int'(nbr_count);
        if (k == 0) begin
            r.thr = radius_sq;
        end else begin
            sorted.sort();
            r.thr = DIST_W'(sorted[k-1]);
        end
        r.idx  = idx;
        r.bits = '0;
        for (int j = 0; j < n; j++)
            if (dist_row[j] < longint'(r.thr)) r.bits[j] = 1'b1;
        return r;
    endfunction

    // Sends one request and updates the mirror once it is taken.
    task automatic send_req(input req_t it);
        int gap;
        bit rdy;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.command     <= it.cmd;
        req_if.point_index <= it.pt;
        req_if.dim_index   <= it.dim;
        req_if.sample      <= it.smp;
        req_if.last        <= it.last;
        do begin
            @(negedge i_clk);
            rdy = req_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        if (it.cmd == CMD_LOAD) begin
            ref_points[it.pt][it.dim] = it.smp;
        end else begin
            query_vec[it.dim] = it.smp;
            if (it.last) rows_pending.push_back(predict_row(it.pt));
        end
    endtask

    task automatic send_fields(input logic cmd, input int pt, input int dim,
                               input logic [SAMPLE_W-1:0] smp, input logic last);
        req_t it;
        it.cmd  = cmd;
        it.pt   = IDX_W'(pt);
        it.dim  = DIDX_W'(dim);
        it.smp  = smp;
        it.last = last;
        send_req(it);
    endtask

    // Waits until every expected row has come, then lets the block settle.
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (rows_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes all four registers back to back; the block must be idle.
    task automatic write_regs(input logic [CFG_W-1:0] thr, input int k,
                              input int n, input int p);
        logic [CFG_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0] idxs [4];
        vals[0] = thr;       idxs[0] = CFG_THRESHOLD;
        vals[1] = CFG_W'(k); idxs[1] = CFG_NEIGHBOUR;
        vals[2] = CFG_W'(n); idxs[2] = CFG_POINTS;
        vals[3] = CFG_W'(p); idxs[3] = CFG_DIMS;
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idxs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        radius_sq = thr[DIST_W-1:0];
        nbr_count = NBR_W'(k);
        n_points  = PTS_W'(n);
        n_dims    = DIMS_W'(p);
    endtask

    // Fills every reference component so later rows never read garbage.
    task automatic test_preload();
        jitter_on = 1'b0;
        for (int j = 0; j < MAX_POINTS; j++)
            for (int d = 0; d < MAX_DIMS; d++)
                send_fields(CMD_LOAD, j, d, pick_sample(), 1'($urandom));
        for (int d = 0; d < MAX_DIMS; d++)
            send_fields(CMD_QUERY, 0, d, pick_sample(), 1'b0);
        wait_idle();
    endtask

    // Largest component differences against the widest radius.
    task automatic test_extremes();
        jitter_on = 1'b1;
        write_regs(CFG_W'(DIST_SAT), 0, 2, 8);
        for (int d = 0; d < MAX_DIMS; d++) begin
            send_fields(CMD_LOAD, 0, d, 16'h7FFF, 1'b1);
            send_fields(CMD_LOAD, 1, d, 16'h8000, 1'b0);
        end
        for (int d = 0; d < MAX_DIMS; d++)
            send_fields(CMD_QUERY, 63, d, 16'h8000, d == MAX_DIMS - 1);
        send_fields(CMD_QUERY, 5, 0, 16'h7FFF, 1'b1);
        wait_idle();
    endtask

    // Repeated distances in neighbour mode, and k beyond the row length.
    task automatic test_ties();
        write_regs('0, 2, 4, 1);
        send_fields(CMD_LOAD, 0, 0, 16'd5, 1'b0);
        send_fields(CMD_LOAD, 1, 0, 16'd5, 1'b0);
        send_fields(CMD_LOAD, 2, 0, 16'd5, 1'b0);
        send_fields(CMD_LOAD, 3, 0, 16'd9, 1'b0);
        send_fields(CMD_QUERY, 1, 0, 16'd5, 1'b1);
        wait_idle();
        write_regs('0, 127, 4, 1);
        send_fields(CMD_QUERY, 2, 0, 16'd5, 1'b1);
        wait_idle();
    endtask

    // One random phase: mostly well-formed rows, the rest loose items.
    task automatic run_phase(input int items);
        int cnt, p, r;
        p = (n_dims < 1) ? 1 : (n_dims > MAX_DIMS) ? MAX_DIMS : int'(n_dims);
        cnt = 0;
        while (cnt < items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                repeat ($urandom_range(0, 3)) begin
                    send_fields(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 7),
                                pick_sample(), 1'($urandom));
                    cnt++;
                end
                for (int d = 0; d < p; d++) begin
                    send_fields(CMD_QUERY, $urandom_range(0, 63), d, pick_sample(),
                                d == p - 1);
                    cnt++;
                end
            end else begin
                send_fields(1'($urandom), $urandom_range(0, 63), $urandom_range(0, 7),
                            pick_sample(), ($urandom_range(0, 3) == 0));
                cnt++;
            end
        end
        wait_idle();
    endtask

    // Register sweep with extremes first, then random settings.
    task automatic test_random_phases();
        logic [CFG_W-1:0] thr;
        int n;
        for (int ph = 0; ph < 9; ph++) begin
            jitter_on = (ph % 3 != 1);
            thr = CFG_W'({$urandom, $urandom});
            case (ph)
                0: write_regs('0, 0, 64, 1);
                1: write_regs(CFG_W'(DIST_SAT), 0, 0, 0);
                2: write_regs(thr, 127, 127, 15);
                3: write_regs(thr, 64, 64, 8);
                4: write_regs(CFG_W'($urandom_range(0, 1 << 20)), 0, 12, 2);
                default: begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                    : $urandom_range(1, 12);
                    write_regs(($urandom_range(0, 1)) ? thr
                                   : CFG_W'($urandom_range(0, 1 << 24)),
                               $urandom_range(0, 1) ? $urandom_range(1, n + 2) : 0,
                               n, $urandom_range(1, 8));
                end
            endcase
            run_phase(22);
        end
    endtask

    // Result side: random stalls, with calm stretches when jitter is off.
    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                stall--;
            end else begin
                stall = pick_gap();
                rsp_if.ready <= (stall == 0);
            end
        end
    end

    // Result check and watchdog, sampled between edges.
    always @(negedge i_clk) begin
        row_t exp_row;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rows_pending.size() == 0) begin
                $display("%0t: unexpected row, actual idx=%0d bits=%h thr=%h", $time,
                         rsp_if.row_index, rsp_if.row_bits, rsp_if.row_threshold_sq);
                errors++;
            end else begin
                exp_row = rows_pending.pop_front();
                if (rsp_if.row_index !== exp_row.idx) begin
                    $display("%0t: row_index expected %0d actual %0d", $time,
                             exp_row.idx, rsp_if.row_index);
                    errors++;
                end
                if (rsp_if.row_bits !== exp_row.bits) begin
                    $display("%0t: row_bits expected %h actual %h", $time,
                             exp_row.bits, rsp_if.row_bits);
                    errors++;
                end
                if (rsp_if.row_threshold_sq !== exp_row.thr) begin
                    $display("%0t: row_threshold_sq expected %h actual %h", $time,
                             exp_row.thr, rsp_if.row_threshold_sq);
                    errors++;
                end
            end
        end
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        errors      = 0;
        idle_cycles = 0;
        jitter_on   = 1'b0;
        radius_sq   = '0;
        nbr_count   = '0;
        n_points    = PTS_W'(MAX_POINTS);
        n_dims      = DIMS_W'(1);
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_THRESHOLD;
        i_cfg_data         <= '0;
        req_if.valid       <= 1'b0;
        req_if.command     <= CMD_LOAD;
        req_if.point_index <= '0;
        req_if.dim_index   <= '0;
        req_if.sample      <= '0;
        req_if.last        <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_preload();
        test_extremes();
        test_ties();
        test_random_phases();

        wait_idle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
